// File: hw/rtl/tlc_pkg.sv
// Shared types and constants for the three-level two-way cache lookup.
// No dependencies; used by the top level, tlc_ctrl and tlc_datapath.
package tlc_pkg;

  localparam int ADDR_W  = 16;
  localparam int COST_W  = 16;
  localparam int LVL_W   = 2;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_W   = 2;

  localparam logic [LVL_W-1:0] LVL_FIRST  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_SECOND = 2'd1;
  localparam logic [LVL_W-1:0] LVL_THIRD  = 2'd2;
  localparam logic [LVL_W-1:0] LVL_MEMORY = 2'd3;

  localparam logic [REG_W-1:0] REG_COST_L1  = 2'd0;
  localparam logic [REG_W-1:0] REG_COST_L2  = 2'd1;
  localparam logic [REG_W-1:0] REG_COST_L3  = 2'd2;
  localparam logic [REG_W-1:0] REG_COST_MEM = 2'd3;

  localparam logic [COST_W-1:0] COST_L1_RST  = 16'd10;
  localparam logic [COST_W-1:0] COST_L2_RST  = 16'd110;
  localparam logic [COST_W-1:0] COST_L3_RST  = 16'd1110;
  localparam logic [COST_W-1:0] COST_MEM_RST = 16'd11110;

  typedef struct packed {
    logic capture;
    logic commit;
  } tlc_cmd_t;

endpackage

// File: hw/rtl/three_level_two_way_cache_lookup.sv
// Top level of the three-level two-way cache lookup: cost registers on the
// APB port, controller and datapath. Depends on tlc_pkg, tlc_ctrl, tlc_datapath.
//
//   Channel  Direction  Handshake                 Word
//   in_      input      in_valid / in_ready       block address
//   out_     output     out_valid / out_ready     hit level, access cost, filled way
//   cfg      input      psel, penable, pwrite     four 16-bit cost registers
//
// Each word passes an accept state, then a compare and tag write-back state;
// the split is set by the registered read of the tag memories. The next word
// is accepted the cycle after the result is registered. A result not taken
// holds the lookup of the following word in its compare cycle. Reset clears
// all valid and recency bits at once; there is no clearing pass.
module three_level_two_way_cache_lookup #(
  parameter int FIRST_SETS   = 16,
  parameter int SECOND_SETS  = 32,
  parameter int THIRD_SETS   = 64,
  parameter int ADDRESS_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tlc_pkg::ADDR_W-1:0]   in_block_address,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tlc_pkg::LVL_W-1:0]    out_hit_level,
  output logic [tlc_pkg::COST_W-1:0]   out_access_cost,
  output logic                         out_filled_way,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tlc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tlc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  tlc_pkg::tlc_cmd_t          cmd;
  logic [tlc_pkg::COST_W-1:0] cost_l1_r;
  logic [tlc_pkg::COST_W-1:0] cost_l2_r;
  logic [tlc_pkg::COST_W-1:0] cost_l3_r;
  logic [tlc_pkg::COST_W-1:0] cost_mem_r;
  logic [tlc_pkg::REG_W-1:0]  reg_idx;
  logic [tlc_pkg::COST_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign reg_idx = paddr[tlc_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_l1_r  <= tlc_pkg::COST_L1_RST;
      cost_l2_r  <= tlc_pkg::COST_L2_RST;
      cost_l3_r  <= tlc_pkg::COST_L3_RST;
      cost_mem_r <= tlc_pkg::COST_MEM_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        tlc_pkg::REG_COST_L1:  cost_l1_r  <= pwdata[tlc_pkg::COST_W-1:0];
        tlc_pkg::REG_COST_L2:  cost_l2_r  <= pwdata[tlc_pkg::COST_W-1:0];
        tlc_pkg::REG_COST_L3:  cost_l3_r  <= pwdata[tlc_pkg::COST_W-1:0];
        tlc_pkg::REG_COST_MEM: cost_mem_r <= pwdata[tlc_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlc_pkg::REG_COST_L1:  rd_val = cost_l1_r;
      tlc_pkg::REG_COST_L2:  rd_val = cost_l2_r;
      tlc_pkg::REG_COST_L3:  rd_val = cost_l3_r;
      default:               rd_val = cost_mem_r;
    endcase
  end

  assign prdata = tlc_pkg::PDATA_W'(rd_val);

  tlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  tlc_datapath #(
    .FIRST_SETS  (FIRST_SETS),
    .SECOND_SETS (SECOND_SETS),
    .THIRD_SETS  (THIRD_SETS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_block_address(in_block_address),
    .cost_l1         (cost_l1_r),
    .cost_l2         (cost_l2_r),
    .cost_l3         (cost_l3_r),
    .cost_mem        (cost_mem_r),
    .out_hit_level   (out_hit_level),
    .out_access_cost (out_access_cost),
    .out_filled_way  (out_filled_way)
  );

endmodule

// File: hw/rtl/tlc_tag_ram.sv
// Single-port-write, single-port-read tag memory with registered read data.
// No dependencies.
module tlc_tag_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tlc_ctrl.sv
// Controller for the cache lookup: accept, lookup and result handoff.
// Depends on tlc_pkg for the command struct.
module tlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tlc_pkg::tlc_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && (state_r == ST_IDLE);
  assign cmd.commit  = (state_r == ST_LOOK) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (cmd.capture) begin
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (cmd.commit) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_capture_starts_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_LOOK))
    else $error("Accepted word did not start a lookup.");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && state_r == ST_IDLE))
    else $error("Committed lookup did not present a result.");

  a_stalled_lookup_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && !cmd.commit) |=> (state_r == ST_LOOK))
    else $error("Stalled lookup left its state.");

endmodule

// File: hw/rtl/tlc_datapath.sv
// Datapath of the cache lookup: tag memories, valid and recency bits,
// tag compare, fill selection and the result register. Depends on tlc_pkg and tlc_tag_ram.
module tlc_datapath #(
  parameter int FIRST_SETS   = 16,
  parameter int SECOND_SETS  = 32,
  parameter int THIRD_SETS   = 64,
  parameter int ADDRESS_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tlc_pkg::tlc_cmd_t           cmd,
  input  logic [tlc_pkg::ADDR_W-1:0]  in_block_address,
  input  logic [tlc_pkg::COST_W-1:0]  cost_l1,
  input  logic [tlc_pkg::COST_W-1:0]  cost_l2,
  input  logic [tlc_pkg::COST_W-1:0]  cost_l3,
  input  logic [tlc_pkg::COST_W-1:0]  cost_mem,
  output logic [tlc_pkg::LVL_W-1:0]   out_hit_level,
  output logic [tlc_pkg::COST_W-1:0]  out_access_cost,
  output logic                        out_filled_way
);

  localparam int TAG_W = (ADDRESS_BITS < tlc_pkg::ADDR_W) ? ADDRESS_BITS : tlc_pkg::ADDR_W;
  localparam int S1_W  = $clog2(FIRST_SETS > 1 ? FIRST_SETS : 2);
  localparam int S2_W  = $clog2(SECOND_SETS > 1 ? SECOND_SETS : 2);
  localparam int S3_W  = $clog2(THIRD_SETS > 1 ? THIRD_SETS : 2);

  function automatic logic pick_way(input logic [1:0] valid, input logic recent);
    logic w;
    if (!valid[0]) begin
      w = 1'b0;
    end else if (!valid[1]) begin
      w = 1'b1;
    end else begin
      w = ~recent;
    end
    return w;
  endfunction

  logic [TAG_W-1:0] addr_in;
  logic [TAG_W-1:0] addr_r;
  logic [TAG_W-1:0] addr_nxt;
  logic [TAG_W-1:0] rd_addr;
  logic [S1_W-1:0]  rs1, s1;
  logic [S2_W-1:0]  rs2, s2;
  logic [S3_W-1:0]  rs3, s3;

  logic [TAG_W-1:0] t1_q [2];
  logic [TAG_W-1:0] t2_q [2];
  logic [TAG_W-1:0] t3_q [2];

  logic [FIRST_SETS-1:0][1:0]  v1_r;
  logic [SECOND_SETS-1:0][1:0] v2_r;
  logic [THIRD_SETS-1:0][1:0]  v3_r;
  logic [FIRST_SETS-1:0]       r1_r;
  logic [SECOND_SETS-1:0]      r2_r;
  logic [THIRD_SETS-1:0]       r3_r;

  logic [1:0] h1, h2, h3;
  logic       hit1, hit2, hit3;
  logic       w1, w2, w3;
  logic       f1, f2, f3;
  logic       fill1, fill2, fill3;

  logic [tlc_pkg::LVL_W-1:0]  lvl;
  logic [tlc_pkg::COST_W-1:0] cost;
  logic [tlc_pkg::LVL_W-1:0]  hit_level_r;
  logic [tlc_pkg::COST_W-1:0] access_cost_r;
  logic                       filled_way_r;

  assign addr_in  = in_block_address[TAG_W-1:0];
  assign addr_nxt = cmd.capture ? addr_in : addr_r;
  assign rd_addr  = cmd.capture ? addr_in : addr_r;

  assign rs1 = S1_W'(rd_addr % FIRST_SETS);
  assign rs2 = S2_W'(rd_addr % SECOND_SETS);
  assign rs3 = S3_W'(rd_addr % THIRD_SETS);
  assign s1  = S1_W'(addr_r % FIRST_SETS);
  assign s2  = S2_W'(addr_r % SECOND_SETS);
  assign s3  = S3_W'(addr_r % THIRD_SETS);

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

  for (genvar w = 0; w < 2; w++) begin : g_way
    tlc_tag_ram #(.DEPTH(FIRST_SETS), .WIDTH(TAG_W)) u_l1 (
      .clk  (clk),
      .we   (cmd.commit && fill1 && (f1 == 1'(w))),
      .waddr(s1),
      .wdata(addr_r),
      .raddr(rs1),
      .rdata(t1_q[w])
    );
    tlc_tag_ram #(.DEPTH(SECOND_SETS), .WIDTH(TAG_W)) u_l2 (
      .clk  (clk),
      .we   (cmd.commit && fill2 && (f2 == 1'(w))),
      .waddr(s2),
      .wdata(addr_r),
      .raddr(rs2),
      .rdata(t2_q[w])
    );
    tlc_tag_ram #(.DEPTH(THIRD_SETS), .WIDTH(TAG_W)) u_l3 (
      .clk  (clk),
      .we   (cmd.commit && fill3 && (f3 == 1'(w))),
      .waddr(s3),
      .wdata(addr_r),
      .raddr(rs3),
      .rdata(t3_q[w])
    );
    assign h1[w] = v1_r[s1][w] && (t1_q[w] == addr_r);
    assign h2[w] = v2_r[s2][w] && (t2_q[w] == addr_r);
    assign h3[w] = v3_r[s3][w] && (t3_q[w] == addr_r);
  end

  assign hit1 = |h1;
  assign hit2 = |h2;
  assign hit3 = |h3;
  assign w1   = ~h1[0];
  assign w2   = ~h2[0];
  assign w3   = ~h3[0];
  assign f1   = pick_way(v1_r[s1], r1_r[s1]);
  assign f2   = pick_way(v2_r[s2], r2_r[s2]);
  assign f3   = pick_way(v3_r[s3], r3_r[s3]);

  assign fill1 = !hit1;
  assign fill2 = !hit1 && !hit2;
  assign fill3 = !hit1 && !hit2 && !hit3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= '0;
      v2_r <= '0;
      v3_r <= '0;
      r1_r <= '0;
      r2_r <= '0;
      r3_r <= '0;
    end else if (cmd.commit) begin
      if (hit1) begin
        r1_r[s1] <= w1;
      end else begin
        v1_r[s1][f1] <= 1'b1;
        r1_r[s1]     <= f1;
      end
      if (!hit1 && hit2) begin
        r2_r[s2] <= w2;
      end else if (fill2) begin
        v2_r[s2][f2] <= 1'b1;
        r2_r[s2]     <= f2;
      end
      if (fill2 && hit3) begin
        r3_r[s3] <= w3;
      end else if (fill3) begin
        v3_r[s3][f3] <= 1'b1;
        r3_r[s3]     <= f3;
      end
    end
  end

  always_comb begin
    if (hit1) begin
      lvl = tlc_pkg::LVL_FIRST;
    end else if (hit2) begin
      lvl = tlc_pkg::LVL_SECOND;
    end else if (hit3) begin
      lvl = tlc_pkg::LVL_THIRD;
    end else begin
      lvl = tlc_pkg::LVL_MEMORY;
    end
  end

  always_comb begin
    case (lvl)
      tlc_pkg::LVL_FIRST:  cost = cost_l1;
      tlc_pkg::LVL_SECOND: cost = cost_l2;
      tlc_pkg::LVL_THIRD:  cost = cost_l3;
      default:             cost = cost_mem;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_level_r   <= lvl;
      access_cost_r <= cost;
      filled_way_r  <= hit1 ? w1 : f1;
    end
  end

  assign out_hit_level   = hit_level_r;
  assign out_access_cost = access_cost_r;
  assign out_filled_way  = filled_way_r;

  a_l1_no_duplicate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(h1[0] && h1[1]))
    else $error("First level holds the same block in both ways.");

  a_l2_no_duplicate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(h2[0] && h2[1]))
    else $error("Second level holds the same block in both ways.");

  a_l3_no_duplicate: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(h3[0] && h3[1]))
    else $error("Third level holds the same block in both ways.");

endmodule
